FILE: rtl/text_line_number_escape_filter_top_assert.svh
// Assertion macros for the text filter block.
// Used by the queue and back-end modules; compiled out under SYNTHESIS.
`ifndef TEXT_LINE_NUMBER_ESCAPE_FILTER_TOP_ASSERT_SVH
`define TEXT_LINE_NUMBER_ESCAPE_FILTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TLEF_ASSERT(lbl, clk_i, rst_i, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) prop) \
    else $error("tlef: assertion failed");
`define TLEF_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("tlef: assertion failed");
`else
`define TLEF_ASSERT(lbl, clk_i, rst_i, prop)
`define TLEF_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons)
`endif
`endif

FILE: rtl/tlef_pkg.sv
// Shared types and constants of the text filter block.
// No dependencies.
package tlef_pkg;

  localparam int NUMBER_DIGITS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF   = 4;
  localparam int MIN_WIDTH         = 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUMBER_MODE      = 3'd0,
    REG_SHOW_ENDS        = 3'd1,
    REG_SQUEEZE_BLANK    = 3'd2,
    REG_SHOW_TABS        = 3'd3,
    REG_SHOW_NONPRINTING = 3'd4
  } reg_idx_t;

  localparam logic [1:0] NUM_OFF = 2'd0;

  localparam logic [7:0] CH_TAB         = 8'h09;
  localparam logic [7:0] CH_NL          = 8'h0A;
  localparam logic [7:0] CH_SPACE       = 8'h20;
  localparam logic [7:0] CH_FIRST_PRINT = 8'h20;
  localparam logic [7:0] CH_DOLLAR      = 8'h24;
  localparam logic [7:0] CH_ZERO        = 8'h30;
  localparam logic [7:0] CH_QMARK       = 8'h3F;
  localparam logic [7:0] CH_I           = 8'h49;
  localparam logic [7:0] CH_CARET       = 8'h5E;
  localparam logic [7:0] CH_DEL         = 8'h7F;
  localparam logic [7:0] CTRL_BIT       = 8'h40;

  typedef struct packed {
    logic [1:0] number_mode;
    logic       show_ends;
    logic       squeeze_blank;
    logic       show_tabs;
    logic       show_nonprinting;
  } cfg_t;

  // Body of one request: optional number prefix flag, then one or two bytes.
  typedef struct packed {
    logic       has_num;
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } body_t;

endpackage

FILE: rtl/tlef_if.sv
// Channel interfaces of the text filter block: text in, filtered out, config.
// Depends on tlef_pkg.
interface tlef_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       file_start;
  modport source (output valid, in_byte, file_start, input ready);
  modport sink   (input valid, in_byte, file_start, output ready);
endinterface

interface tlef_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

interface tlef_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tlef_pkg::CFG_IDX_W-1:0]  index;
  logic [tlef_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/tlef_front.sv
// Front end: accepts text bytes, tracks line state and the BCD line counter,
// classifies each byte into a queue entry. Depends on tlef_pkg, tlef_if.
module tlef_front #(
  parameter int NUMBER_DIGITS = tlef_pkg::NUMBER_DIGITS_DEF,
  parameter int DIGW          = $clog2(NUMBER_DIGITS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tlef_pkg::cfg_t             ctrl,
  tlef_text_if.sink                  text,
  output logic                       push_valid,
  input  logic                       push_ready,
  output tlef_pkg::body_t            push_body,
  output logic [4*NUMBER_DIGITS-1:0] push_digits,
  output logic [DIGW-1:0]            push_msd
);

  logic                       at_line_start;
  logic                       prev_line_blank;
  logic [4*NUMBER_DIGITS-1:0] line_number;
  logic [DIGW-1:0]            msd;

  logic                       is_nl, is_tab, is_del, als, plb, plb_next, drop, do_num, grow;
  logic [4*NUMBER_DIGITS-1:0] num_cur, num_inc;
  logic [DIGW-1:0]            msd_cur, msd_inc;
  logic [NUMBER_DIGITS-1:0]   is9;
  logic [NUMBER_DIGITS:0]     carry;
  logic                       accept;

  assign is_nl  = text.in_byte == tlef_pkg::CH_NL;
  assign is_tab = text.in_byte == tlef_pkg::CH_TAB;
  assign is_del = text.in_byte == tlef_pkg::CH_DEL;

  // new file restores the reset line state before the byte is handled
  assign als     = text.file_start | at_line_start;
  assign plb     = !text.file_start & prev_line_blank;
  assign num_cur = text.file_start ? '0 : line_number;
  assign msd_cur = text.file_start ? '0 : msd;

  assign drop     = als && ctrl.squeeze_blank && is_nl && plb;
  assign plb_next = (als && ctrl.squeeze_blank) ? is_nl : plb;
  // mode bit 1 selects non-blank lines only
  assign do_num   = als && (ctrl.number_mode != tlef_pkg::NUM_OFF) &&
                    (!ctrl.number_mode[1] || !is_nl);

  always_comb begin
    carry[0] = 1'b1;
    grow     = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      is9[i]       = num_cur[4*i +: 4] == 4'd9;
      carry[i+1]   = carry[i] & is9[i];
      num_inc[4*i +: 4] = carry[i] ? (is9[i] ? 4'd0 : num_cur[4*i +: 4] + 4'd1)
                                   : num_cur[4*i +: 4];
      if ((DIGW'(i) <= msd_cur) && !is9[i]) begin
        grow = 1'b0;
      end
    end
    if (!grow) begin
      msd_inc = msd_cur;
    end else if (msd_cur == DIGW'(NUMBER_DIGITS - 1)) begin
      msd_inc = '0;
    end else begin
      msd_inc = msd_cur + 1'b1;
    end
  end

  always_comb begin
    push_body         = '0;
    push_body.has_num = do_num;
    push_body.b0      = text.in_byte;
    push_body.b1      = text.in_byte;
    if (is_nl) begin
      if (ctrl.show_ends) begin
        push_body.b0  = tlef_pkg::CH_DOLLAR;
        push_body.two = 1'b1;
      end
    end else if (is_tab) begin
      if (ctrl.show_tabs) begin
        push_body.b0  = tlef_pkg::CH_CARET;
        push_body.b1  = tlef_pkg::CH_I;
        push_body.two = 1'b1;
      end
    end else if (ctrl.show_nonprinting && (text.in_byte < tlef_pkg::CH_FIRST_PRINT || is_del)) begin
      push_body.b0  = tlef_pkg::CH_CARET;
      push_body.b1  = is_del ? tlef_pkg::CH_QMARK : (text.in_byte | tlef_pkg::CTRL_BIT);
      push_body.two = 1'b1;
    end
  end

  assign push_digits = num_inc;
  assign push_msd    = msd_inc;
  assign push_valid  = text.valid && !drop;
  assign text.ready  = push_ready;
  assign accept      = text.valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start   <= 1'b1;
      prev_line_blank <= 1'b0;
      line_number     <= '0;
      msd             <= '0;
    end else if (accept) begin
      at_line_start   <= is_nl;
      prev_line_blank <= plb_next;
      line_number     <= (do_num && !drop) ? num_inc : num_cur;
      msd             <= (do_num && !drop) ? msd_inc : msd_cur;
    end
  end

endmodule

FILE: rtl/tlef_queue.sv
// Short FIFO between front and back end.
// Depends on tlef_pkg and the assertion header.
`include "text_line_number_escape_filter_top_assert.svh"
module tlef_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tlef_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             head_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_data  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TLEF_ASSERT(q_count_bound, clk, rst, count <= CNT_W'(DEPTH))
  `TLEF_ASSERT_NEXT(q_push_grows, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1)

endmodule

FILE: rtl/tlef_back.sv
// Back end: walks one queue entry per request, emitting prefix pad, digits,
// tab and body bytes into the output register. Depends on tlef_pkg, tlef_if.
`include "text_line_number_escape_filter_top_assert.svh"
module tlef_back #(
  parameter int NUMBER_DIGITS = tlef_pkg::NUMBER_DIGITS_DEF,
  parameter int DIGW          = $clog2(NUMBER_DIGITS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  tlef_pkg::body_t            head_body,
  input  logic [4*NUMBER_DIGITS-1:0] head_digits,
  input  logic [DIGW-1:0]            head_msd,
  output logic                       pop,
  tlef_out_if.source                 filtered
);

  localparam int CNT_W = (DIGW > 3) ? DIGW : 3;

  typedef enum logic [5:0] {
    ST_START = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_DIGIT = 6'b000100,
    ST_TAB   = 6'b001000,
    ST_BODY0 = 6'b010000,
    ST_BODY1 = 6'b100000
  } back_st_t;

  back_st_t         st, st_next, cur_st;
  logic [CNT_W-1:0] cnt, cnt_next, cur_cnt, pad, msd_ext;
  logic             out_valid, can_load, adv, last_n;
  logic [7:0]       byte_n;
  logic [3:0]       digit;

  assign can_load = !out_valid || filtered.ready;
  assign adv      = head_valid && can_load;
  assign msd_ext  = CNT_W'(head_msd);
  assign pad      = (head_msd < DIGW'(tlef_pkg::MIN_WIDTH - 1))
                    ? CNT_W'(tlef_pkg::MIN_WIDTH - 1) - msd_ext : '0;
  assign digit    = head_digits[4*cur_cnt[DIGW-1:0] +: 4];

  always_comb begin
    cur_st  = st;
    cur_cnt = cnt;
    if (st == ST_START) begin
      if (!head_body.has_num) begin
        cur_st  = ST_BODY0;
        cur_cnt = '0;
      end else if (pad != '0) begin
        cur_st  = ST_PAD;
        cur_cnt = pad;
      end else begin
        cur_st  = ST_DIGIT;
        cur_cnt = msd_ext;
      end
    end
  end

  always_comb begin
    st_next  = ST_START;
    cnt_next = '0;
    byte_n   = head_body.b0;
    last_n   = 1'b0;
    unique case (cur_st)
      ST_PAD: begin
        byte_n = tlef_pkg::CH_SPACE;
        if (cur_cnt == CNT_W'(1)) begin
          st_next  = ST_DIGIT;
          cnt_next = msd_ext;
        end else begin
          st_next  = ST_PAD;
          cnt_next = cur_cnt - 1'b1;
        end
      end
      ST_DIGIT: begin
        byte_n = tlef_pkg::CH_ZERO + {4'd0, digit};
        if (cur_cnt == '0) begin
          st_next = ST_TAB;
        end else begin
          st_next  = ST_DIGIT;
          cnt_next = cur_cnt - 1'b1;
        end
      end
      ST_TAB: begin
        byte_n  = tlef_pkg::CH_TAB;
        st_next = ST_BODY0;
      end
      ST_BODY0: begin
        byte_n = head_body.b0;
        last_n = !head_body.two;
        if (head_body.two) begin
          st_next = ST_BODY1;
        end
      end
      ST_BODY1: begin
        byte_n = head_body.b1;
        last_n = 1'b1;
      end
      default: begin
        st_next = ST_START;
      end
    endcase
  end

  assign pop                = adv && last_n;
  assign filtered.valid     = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_START;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        st  <= st_next;
        cnt <= cnt_next;
      end
      if (can_load) begin
        out_valid <= adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      filtered.out_byte    <= byte_n;
      filtered.last_of_run <= last_n;
    end
  end

  `TLEF_ASSERT(bk_digit_in_range, clk, rst,
               (adv && cur_st == ST_DIGIT) |-> (cur_cnt[DIGW-1:0] <= head_msd))
  `TLEF_ASSERT_NEXT(bk_pop_restarts, clk, rst, pop, st == ST_START && out_valid)

endmodule

FILE: rtl/text_line_number_escape_filter_top.sv
// Text filter top level: config registers, front end, queue, back end.
// Depends on tlef_pkg, tlef_if, tlef_front, tlef_queue, tlef_back.
//
// Usage:
//   text     : input bytes (in_byte, file_start); accepted on valid && ready.
//   filtered : output bytes (out_byte, last_of_run); last_of_run marks the
//              final byte produced by one input byte. Dropped blank lines
//              produce nothing.
//   cfg      : register writes (index, data), always ready; write only while
//              idle.
// With the back end idle, an accepted input byte is written into the queue and
// its first output byte is then loaded into the output register. Throughput:
// one output byte per cycle while the queue holds entries and the receiver is
// ready, set by the back-end sequencer; a plain byte gives one output byte, a
// numbered line start adds a max(6, digits) + 1 byte prefix, caret and dollar forms add one.
// A queue of QUEUE_DEPTH entries sits between front and back end.
// Reset: all options off, counter zero, at line start, outputs empty.
// Receiver stall: the output register holds its byte, the queue fills, then
// text.ready drops until the back end drains.
module text_line_number_escape_filter_top #(
  parameter int NUMBER_DIGITS = tlef_pkg::NUMBER_DIGITS_DEF,
  parameter int QUEUE_DEPTH   = tlef_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tlef_text_if.sink  text,
  tlef_out_if.source filtered,
  tlef_cfg_if.sink   cfg
);

  localparam int DIGW    = $clog2(NUMBER_DIGITS);
  localparam int ENTRY_W = $bits(tlef_pkg::body_t) + 4*NUMBER_DIGITS + DIGW;

  tlef_pkg::cfg_t             ctrl;
  logic                       push_valid, push_ready, head_valid, pop;
  tlef_pkg::body_t            push_body, head_body;
  logic [4*NUMBER_DIGITS-1:0] push_digits, head_digits;
  logic [DIGW-1:0]            push_msd, head_msd;
  logic [ENTRY_W-1:0]         push_data, head_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (cfg.valid) begin
      unique case (tlef_pkg::reg_idx_t'(cfg.index))
        tlef_pkg::REG_NUMBER_MODE:      ctrl.number_mode      <= cfg.data[1:0];
        tlef_pkg::REG_SHOW_ENDS:        ctrl.show_ends        <= cfg.data[0];
        tlef_pkg::REG_SQUEEZE_BLANK:    ctrl.squeeze_blank    <= cfg.data[0];
        tlef_pkg::REG_SHOW_TABS:        ctrl.show_tabs        <= cfg.data[0];
        tlef_pkg::REG_SHOW_NONPRINTING: ctrl.show_nonprinting <= cfg.data[0];
        default: ;
      endcase
    end
  end

  tlef_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS),
    .DIGW         (DIGW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .text       (text),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_body  (push_body),
    .push_digits(push_digits),
    .push_msd   (push_msd)
  );

  assign push_data = {push_body, push_digits, push_msd};

  tlef_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .head_valid(head_valid),
    .pop       (pop),
    .head_data (head_data)
  );

  assign {head_body, head_digits, head_msd} = head_data;

  tlef_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS),
    .DIGW         (DIGW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_body  (head_body),
    .head_digits(head_digits),
    .head_msd   (head_msd),
    .pop        (pop),
    .filtered   (filtered)
  );

endmodule
